[rtl/core/ams_pkg.sv]
// Shared types and constants for the adjacency matrix store.
package ams_pkg;

  localparam int unsigned MAX_VERTICES = 16;
  localparam int unsigned VTX_BITS     = $clog2(MAX_VERTICES);
  localparam int unsigned ADDR_BITS    = 2 * VTX_BITS;
  localparam int unsigned DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned CNT_BITS     = 5;
  localparam int unsigned ACT_BITS     = 3;

  localparam logic [CNT_BITS-1:0] VERTEX_COUNT_RESET = CNT_BITS'(16);
  localparam logic [CNT_BITS-1:0] VERTEX_LIMIT       = CNT_BITS'(MAX_VERTICES);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_INSERT = 3'd0,
    ACT_TEST   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_FIRST  = 3'd3,
    ACT_NEXT   = 3'd4
  } ams_action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_RESP
  } ams_state_e;

  typedef struct packed {
    logic                   we;
    logic [ADDR_BITS-1:0]   addr;
    logic [WEIGHT_BITS-1:0] wdata;
  } ams_mem_req_t;

  typedef struct packed {
    logic                   found;
    logic [VTX_BITS-1:0]    neighbor;
    logic [WEIGHT_BITS-1:0] weight;
  } ams_result_t;

endpackage

[rtl/core/ams_wmem.sv]
// Weight matrix RAM with per-entry valid bits; invalid entries read as zero.
module ams_wmem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ams_pkg::ams_mem_req_t           req_i,
  output logic [ams_pkg::WEIGHT_BITS-1:0] rdata_o
);
  import ams_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       vld_q;
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.addr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[rtl/core/ams_ctrl.sv]
// Request sequencer: single-entry actions, row scans over the shared RAM port, cursors.
module ams_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ams_pkg::CNT_BITS-1:0]    vertex_count_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ams_pkg::ACT_BITS-1:0]    action_i,
  input  logic [ams_pkg::VTX_BITS-1:0]    source_vertex_i,
  input  logic [ams_pkg::VTX_BITS-1:0]    target_vertex_i,
  input  logic [ams_pkg::WEIGHT_BITS-1:0] edge_weight_i,
  output ams_pkg::ams_mem_req_t           mem_req_o,
  input  logic [ams_pkg::WEIGHT_BITS-1:0] mem_rdata_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output ams_pkg::ams_result_t            res_o
);
  import ams_pkg::*;

  ams_state_e          state_q, state_d;
  ams_action_e         act_q, act_d;
  logic [VTX_BITS-1:0] src_q, src_d;
  logic [VTX_BITS-1:0] dst_q, dst_d;
  logic [CNT_BITS-1:0] col_q, col_d;
  logic                chk_q, chk_d;
  logic [VTX_BITS-1:0] chk_col_q, chk_col_d;
  logic                rest_q, rest_d;
  ams_result_t         res_q, res_d;
  logic [CNT_BITS-1:0] cursor_q [MAX_VERTICES];
  logic                cur_we;
  logic [CNT_BITS-1:0] cur_wdata;
  logic [CNT_BITS-1:0] lim;
  logic [CNT_BITS-1:0] cur_rd;
  logic                hit;

  assign lim    = (vertex_count_i > VERTEX_LIMIT) ? VERTEX_LIMIT : vertex_count_i;
  assign cur_rd = cursor_q[source_vertex_i];
  assign hit    = (mem_rdata_i != '0);

  always_comb begin
    state_d        = state_q;
    act_d          = act_q;
    src_d          = src_q;
    dst_d          = dst_q;
    col_d          = col_q;
    chk_d          = 1'b0;
    chk_col_d      = chk_col_q;
    rest_d         = rest_q;
    res_d          = res_q;
    cur_we         = 1'b0;
    cur_wdata      = lim;
    mem_req_o      = '0;
    mem_req_o.addr = {src_q, dst_q};
    in_stall_o     = (state_q != ST_IDLE);
    res_valid_o    = (state_q == ST_RESP);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d          = ams_action_e'(action_i);
          src_d          = source_vertex_i;
          dst_d          = target_vertex_i;
          res_d          = '0;
          mem_req_o.addr = {source_vertex_i, target_vertex_i};
          case (action_i)
            ACT_INSERT: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.wdata = edge_weight_i;
              state_d         = ST_RESP;
            end
            ACT_TEST, ACT_REMOVE: begin
              state_d = ST_LOOK;
            end
            ACT_FIRST: begin
              col_d   = '0;
              rest_d  = 1'b1;
              state_d = ST_SCAN;
            end
            ACT_NEXT: begin
              col_d   = cur_rd;
              rest_d  = (cur_rd <= lim);
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_LOOK: begin
        if (hit) begin
          res_d.found    = 1'b1;
          res_d.neighbor = dst_q;
          res_d.weight   = mem_rdata_i;
          if (act_q == ACT_REMOVE) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = '0;
          end
        end
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        if (chk_q && hit) begin
          res_d.found    = 1'b1;
          res_d.neighbor = chk_col_q;
          res_d.weight   = mem_rdata_i;
          cur_we         = 1'b1;
          cur_wdata      = {1'b0, chk_col_q} + CNT_BITS'(1);
          state_d        = ST_RESP;
        end else if (col_q < lim) begin
          mem_req_o.addr = {src_q, col_q[VTX_BITS-1:0]};
          chk_d          = 1'b1;
          chk_col_d      = col_q[VTX_BITS-1:0];
          col_d          = col_q + CNT_BITS'(1);
        end else begin
          cur_we  = rest_q;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chk_q   <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        cursor_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      if (cur_we) begin
        cursor_q[src_q] <= cur_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    col_q     <= col_d;
    chk_col_q <= chk_col_d;
    rest_q    <= rest_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule

[rtl/core/adjacency_matrix_store.sv]
// Adjacency matrix store top level: config register, sequencer, RAM, output word register.
//
// Input channel: in_valid_i / in_stall_o with action, source, target and weight.
// Output channel: out_valid_o / out_stall_i with found, neighbor and weight.
// A word moves when valid is high and stall is low. Every request gives one
// result word.
// Insert writes the entry on acceptance; test and remove read it, and remove
// clears it on a hit; first scans the row from column 0 and next from the
// row's cursor, over columns below limit = min(vertex_count, 16); the scan
// reads one matrix entry a cycle through the single RAM read port. One
// request is in work at a time; in_stall_o is high until its result has
// moved into the output register, so the next request can be taken in the cycle after.
// The output register takes a new result while the old one leaves, so a
// request can be accepted while a finished result waits on a stall.
// vertex_count is written through cfg_we_i / cfg_wdata_i only while idle; the user
// keeps to that; the block does not enforce it. Reset clears the matrix at once via
// per-entry valid bits, zeroes all scan cursors and sets vertex_count to 16.
module adjacency_matrix_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ams_pkg::CNT_BITS-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ams_pkg::ACT_BITS-1:0]    action_i,
  input  logic [ams_pkg::VTX_BITS-1:0]    source_vertex_i,
  input  logic [ams_pkg::VTX_BITS-1:0]    target_vertex_i,
  input  logic [ams_pkg::WEIGHT_BITS-1:0] edge_weight_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [ams_pkg::VTX_BITS-1:0]    neighbor_vertex_o,
  output logic [ams_pkg::WEIGHT_BITS-1:0] found_weight_o
);
  import ams_pkg::*;

  logic [CNT_BITS-1:0] vcount_q;
  ams_mem_req_t        mem_req;
  logic [WEIGHT_BITS-1:0] mem_rdata;
  logic                res_valid;
  logic                res_ready;
  ams_result_t         res;
  logic                out_valid_q;
  ams_result_t         out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VERTEX_COUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  ams_wmem u_wmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ams_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .vertex_count_i  (vcount_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .source_vertex_i (source_vertex_i),
    .target_vertex_i (target_vertex_i),
    .edge_weight_i   (edge_weight_i),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = out_q.found;
  assign neighbor_vertex_o = out_q.neighbor;
  assign found_weight_o    = out_q.weight;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.neighbor == '0 && out_q.weight == '0)
    else $error("miss result carries nonzero fields");

  a_hit_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.found |-> out_q.weight != '0)
    else $error("found result with zero weight");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in work");

endmodule

[sim/adjacency_matrix_store_tb.sv]
// Self-checking testbench for adjacency_matrix_store: directed table, then random request phases.
`timescale 1ns / 1ps

module adjacency_matrix_store_tb;
  import ams_pkg::*;

  localparam int PHASE_ITEMS    = 90;
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [ACT_BITS-1:0] ACT_RSVD_LO = ACT_BITS'(ACT_NEXT + 1);
  localparam logic [ACT_BITS-1:0] ACT_RSVD_HI = {ACT_BITS{1'b1}};

  typedef struct packed {
    logic [ACT_BITS-1:0]    act;
    logic [VTX_BITS-1:0]    src;
    logic [VTX_BITS-1:0]    dst;
    logic [WEIGHT_BITS-1:0] wt;
  } edge_req_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_CHK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    edge_req_t   req;
    ams_result_t want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CNT_BITS-1:0]    cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [ACT_BITS-1:0]    action_i;
  logic [VTX_BITS-1:0]    source_vertex_i;
  logic [VTX_BITS-1:0]    target_vertex_i;
  logic [WEIGHT_BITS-1:0] edge_weight_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   found_o;
  logic [VTX_BITS-1:0]    neighbor_vertex_o;
  logic [WEIGHT_BITS-1:0] found_weight_o;

  adjacency_matrix_store dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .source_vertex_i   (source_vertex_i),
    .target_vertex_i   (target_vertex_i),
    .edge_weight_i     (edge_weight_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .found_o           (found_o),
    .neighbor_vertex_o (neighbor_vertex_o),
    .found_weight_o    (found_weight_o)
  );

  // predicted graph state
  logic [WEIGHT_BITS-1:0] edge_w [MAX_VERTICES][MAX_VERTICES];
  int unsigned            row_cursor [MAX_VERTICES];
  logic [CNT_BITS-1:0]    vtx_count;

  ams_result_t pending_results [$];
  dir_row_t    dir_tab [$];

  int tx_idle_pct   = 18;
  int rx_stall_pct  = 18;
  int rx_hold       = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int words_in      = 0;
  int words_checked = 0;
  int cfg_writes    = 0;
  int walk_left     = 0;
  logic [VTX_BITS-1:0] walk_row = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic ams_result_t graph_predict(input edge_req_t r);
    ams_result_t res;
    int unsigned lim;
    int unsigned start;
    bit          hit;
    res = '0;
    hit = 1'b0;
    lim = (vtx_count < MAX_VERTICES) ? vtx_count : MAX_VERTICES;
    case (r.act)
      ACT_INSERT: edge_w[r.src][r.dst] = r.wt;
      ACT_TEST, ACT_REMOVE: begin
        if (edge_w[r.src][r.dst] != '0) begin
          res.found    = 1'b1;
          res.neighbor = r.dst;
          res.weight   = edge_w[r.src][r.dst];
          if (r.act == ACT_REMOVE) edge_w[r.src][r.dst] = '0;
        end
      end
      ACT_FIRST, ACT_NEXT: begin
        start = (r.act == ACT_FIRST) ? 0 : row_cursor[r.src];
        for (int unsigned c = start; c < lim && !hit; c++) begin
          if (edge_w[r.src][c] != '0) begin
            hit          = 1'b1;
            res.found    = 1'b1;
            res.neighbor = VTX_BITS'(c);
            res.weight   = edge_w[r.src][c];
            row_cursor[r.src] = c + 1;
          end
        end
        // on a miss the cursor parks at the limit unless a next request finds it already past it
        if (!hit && (row_cursor[r.src] < lim || start <= lim)) row_cursor[r.src] = lim;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic edge_req_t next_random_request();
    edge_req_t r;
    int        p;
    r.src = ($urandom_range(99, 0) < 60) ? VTX_BITS'($urandom_range(3, 0))
                                         : VTX_BITS'($urandom_range(15, 0));
    r.dst = ($urandom_range(99, 0) < 50) ? VTX_BITS'($urandom_range(7, 0))
                                         : VTX_BITS'($urandom_range(15, 0));
    p = $urandom_range(99, 0);
    if (p < 10) r.wt = '0;
    else if (p < 15) r.wt = '1;
    else if (p < 20) r.wt = WEIGHT_BITS'(1) << $urandom_range(WEIGHT_BITS - 1, 0);
    else r.wt = WEIGHT_BITS'($urandom);
    p = $urandom_range(99, 0);
    if (walk_left > 0) begin
      walk_left--;
      r.act = ACT_NEXT;
      r.src = walk_row;
    end else if (p < 12) begin
      r.act     = ACT_FIRST;
      walk_row  = r.src;
      walk_left = $urandom_range(6, 1);
    end else if (p < 40) begin
      r.act = ACT_INSERT;
    end else if (p < 55) begin
      r.act = ACT_TEST;
    end else if (p < 67) begin
      r.act = ACT_REMOVE;
    end else if (p < 92) begin
      r.act = ACT_NEXT;
    end else begin
      r.act = ACT_BITS'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
    end
    return r;
  endfunction

  task automatic tab(input row_kind_e k, input logic [ACT_BITS-1:0] a, input int s,
                     input int d, input int w, input int f, input int nb, input int fw);
    dir_row_t r;
    r.kind          = k;
    r.req.act       = a;
    r.req.src       = VTX_BITS'(s);
    r.req.dst       = VTX_BITS'(d);
    r.req.wt        = WEIGHT_BITS'(w);
    r.want.found    = 1'(f);
    r.want.neighbor = VTX_BITS'(nb);
    r.want.weight   = WEIGHT_BITS'(fw);
    dir_tab.push_back(r);
  endtask

  // entered and left at a falling edge
  task automatic offer_word(input edge_req_t r, input bit typed, input ams_result_t want);
    ams_result_t calc;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= r.act;
    source_vertex_i <= r.src;
    target_vertex_i <= r.dst;
    edge_weight_i   <= r.wt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    calc = graph_predict(r);
    pending_results.push_back(typed ? want : calc);
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CNT_BITS-1:0] v);
    wait_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    vtx_count = v;
    cfg_writes++;
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_stall_i <= 1'b1;
        rx_hold--;
      end else begin
        out_stall_i <= ($urandom_range(99, 0) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    ams_result_t got;
    ams_result_t exp_r;
    if (rst_ni) begin
      got.found    = found_o;
      got.neighbor = neighbor_vertex_o;
      got.weight   = found_weight_o;
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word found=%0d neighbor=%0d weight=%h",
                   $time, got.found, got.neighbor, got.weight);
        end else begin
          exp_r = pending_results.pop_front();
          words_checked++;
          if (got.found !== exp_r.found || got.neighbor !== exp_r.neighbor ||
              got.weight !== exp_r.weight) begin
            mismatches++;
            $display("%0t: mismatch exp found/nb/wt %0d/%0d/%h got %0d/%0d/%h",
                     $time, exp_r.found, exp_r.neighbor, exp_r.weight,
                     got.found, got.neighbor, got.weight);
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("adjacency_matrix_store regression: fail");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t row;
    int       vc_pick;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    action_i        <= ACT_INSERT;
    source_vertex_i <= '0;
    target_vertex_i <= '0;
    edge_weight_i   <= '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      row_cursor[i] = 0;
      for (int j = 0; j < MAX_VERTICES; j++) edge_w[i][j] = '0;
    end
    vtx_count = VERTEX_COUNT_RESET;

    tab(ROW_CHK, ACT_TEST,    0,  0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_FIRST,   15, 0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_INSERT,  0,  15, 'hFFFF, 0, 0,  0);
    tab(ROW_CHK, ACT_TEST,    0,  15, 0,     1, 15, 'hFFFF);
    tab(ROW_CHK, ACT_INSERT,  15, 0, 'h0001, 0, 0,  0);
    tab(ROW_CHK, ACT_INSERT,  15, 15, 'h8000, 0, 0, 0);
    tab(ROW_CHK, ACT_FIRST,   15, 3, 0,      1, 0,  'h0001);
    tab(ROW_CHK, ACT_NEXT,    15, 0, 0,      1, 15, 'h8000);
    tab(ROW_CHK, ACT_NEXT,    15, 0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_NEXT,    15, 0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_REMOVE,  15, 0, 0,      1, 0,  'h0001);
    tab(ROW_CHK, ACT_REMOVE,  15, 0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_INSERT,  0,  15, 0,     0, 0,  0);
    tab(ROW_CHK, ACT_TEST,    0,  15, 0,     0, 0,  0);
    tab(ROW_CHK, ACT_RSVD_LO, 15, 15, 'hFFFF, 0, 0, 0);
    tab(ROW_CHK, ACT_BITS'(ACT_RSVD_LO + 1), 15, 15, 0, 0, 0, 0);
    tab(ROW_REQ, ACT_RSVD_HI, 15, 15, 'h5A5A, 0, 0, 0);
    tab(ROW_CHK, ACT_TEST,    15, 15, 0,     1, 15, 'h8000);
    tab(ROW_CFG, ACT_INSERT,  0,  0, 1,      0, 0,  0);
    tab(ROW_CHK, ACT_FIRST,   15, 0, 0,      0, 0,  0);
    // vertices past vertex_count still take edges
    tab(ROW_REQ, ACT_INSERT,  9,  0, 'hA5A5, 0, 0,  0);
    tab(ROW_CHK, ACT_FIRST,   9,  0, 0,      1, 0,  'hA5A5);
    tab(ROW_CFG, ACT_INSERT,  0,  0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_FIRST,   9,  0, 0,      0, 0,  0);
    tab(ROW_CHK, ACT_TEST,    9,  0, 0,      1, 0,  'hA5A5);
    tab(ROW_CFG, ACT_INSERT,  0,  0, 31,     0, 0,  0);
    tab(ROW_CHK, ACT_FIRST,   15, 0, 0,      1, 15, 'h8000);
    // cursor now past a lowered limit
    tab(ROW_CFG, ACT_INSERT,  0,  0, 4,      0, 0,  0);
    tab(ROW_CHK, ACT_NEXT,    15, 0, 0,      0, 0,  0);
    tab(ROW_CFG, ACT_INSERT,  0,  0, 16,     0, 0,  0);
    tab(ROW_REQ, ACT_NEXT,    15, 0, 0,      0, 0,  0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < dir_tab.size(); i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_CFG) write_vertex_count(row.req.wt[CNT_BITS-1:0]);
      else offer_word(row.req, row.kind == ROW_CHK, row.want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: vc_pick = 16;
        1: vc_pick = 8;
        2: vc_pick = 1;
        3: vc_pick = 0;
        4: vc_pick = 31;
        5: vc_pick = 3;
        6: vc_pick = 16;
        default: vc_pick = $urandom_range(31, 0);
      endcase
      write_vertex_count(CNT_BITS'(vc_pick));
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
      if (ph == 4) rx_hold = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
        offer_word(next_random_request(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("covered %0d requests, %0d result words checked, %0d vertex_count writes",
             words_in, words_checked, cfg_writes);
    $display("incl. row scans past the limit, reserved actions, long output hold, full drain");
    if (mismatches == 0) begin
      $display("adjacency_matrix_store regression: pass");
    end else begin
      $display("adjacency_matrix_store regression: fail");
    end
    $finish;
  end

endmodule

[adjacency_matrix_store.f]
rtl/core/ams_pkg.sv
rtl/core/ams_wmem.sv
rtl/core/ams_ctrl.sv
rtl/core/adjacency_matrix_store.sv
sim/adjacency_matrix_store_tb.sv
